// ===== src/ctbd_pkg.sv =====
package ctbd_pkg;

   // compression_mode codes; the spare code decodes as DXT1
   localparam logic [1:0] MODE_DXT1 = 2'd0;
   localparam logic [1:0] MODE_DXT3 = 2'd1;
   localparam logic [1:0] MODE_DXT5 = 2'd2;

   // register index of compression_mode
   localparam logic REG_MODE = 1'b0;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

   // decoded block, ready for texel-by-texel emission
   typedef struct packed {
      logic [3:0][7:0]  red;
      logic [3:0][7:0]  green;
      logic [3:0][7:0]  blue;
      logic [15:0][1:0] sel;
      logic [15:0][7:0] alpha;
   } block_type;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [7:0] widen4(input logic [3:0] v);
      return {v, v};
   endfunction

   // floor(x/3) for x <= 765 by reciprocal multiply
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [20:0] p;
      p = 21'(x) * 21'd683;
      return p[18:11];
   endfunction

   // floor(x/5) for x <= 1275
   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'd3277;
      return p[21:14];
   endfunction

   // floor(x/7) for x <= 1785
   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'd2341;
      return p[21:14];
   endfunction

endpackage

// ===== src/ctbd_palette.sv =====
module ctbd_palette (
   input  logic [63:0]        colour_word,
   input  logic [63:0]        alpha_word,
   input  logic               punch,
   input  logic               explicit_alpha,
   output ctbd_pkg::block_type blk
);

   logic [15:0]      c0, c1;
   logic             three;
   logic [7:0]       r0, g0, b0, r1, g1, b1;
   logic [7:0]       a0, a1;
   logic [7:0][7:0]  apal;
   logic [10:0]      num;
   logic [2:0]       ai;

   assign c0    = colour_word[15:0];
   assign c1    = colour_word[31:16];
   assign three = punch && (c0 <= c1);

   assign r0 = ctbd_pkg::widen5(c0[15:11]);
   assign g0 = ctbd_pkg::widen6(c0[10:5]);
   assign b0 = ctbd_pkg::widen5(c0[4:0]);
   assign r1 = ctbd_pkg::widen5(c1[15:11]);
   assign g1 = ctbd_pkg::widen6(c1[10:5]);
   assign b1 = ctbd_pkg::widen5(c1[4:0]);

   assign a0 = alpha_word[7:0];
   assign a1 = alpha_word[15:8];

   // interpolated alpha palette: eight entries, or six plus clear and opaque
   always_comb begin
      apal    = '0;
      apal[0] = a0;
      apal[1] = a1;
      num     = '0;
      if (a0 > a1) begin
         for (int i = 1; i < 7; i++) begin
            num         = 11'(7 - i) * 11'(a0) + 11'(i) * 11'(a1);
            apal[i + 1] = ctbd_pkg::div7(num);
         end
      end else begin
         for (int i = 1; i < 5; i++) begin
            num         = 11'(5 - i) * 11'(a0) + 11'(i) * 11'(a1);
            apal[i + 1] = ctbd_pkg::div5(num);
         end
         apal[6] = ctbd_pkg::ALPHA_CLEAR;
         apal[7] = ctbd_pkg::ALPHA_OPAQUE;
      end
   end

   always_comb begin
      blk.red[0]   = r0;
      blk.green[0] = g0;
      blk.blue[0]  = b0;
      blk.red[1]   = r1;
      blk.green[1] = g1;
      blk.blue[1]  = b1;
      if (three) begin
         blk.red[2]   = 8'(({1'b0, r0} + {1'b0, r1}) >> 1);
         blk.green[2] = 8'(({1'b0, g0} + {1'b0, g1}) >> 1);
         blk.blue[2]  = 8'(({1'b0, b0} + {1'b0, b1}) >> 1);
         blk.red[3]   = '0;
         blk.green[3] = '0;
         blk.blue[3]  = '0;
      end else begin
         blk.red[2]   = ctbd_pkg::div3({1'b0, r0, 1'b0} + 10'(r1));
         blk.green[2] = ctbd_pkg::div3({1'b0, g0, 1'b0} + 10'(g1));
         blk.blue[2]  = ctbd_pkg::div3({1'b0, b0, 1'b0} + 10'(b1));
         blk.red[3]   = ctbd_pkg::div3(10'(r0) + {1'b0, r1, 1'b0});
         blk.green[3] = ctbd_pkg::div3(10'(g0) + {1'b0, g1, 1'b0});
         blk.blue[3]  = ctbd_pkg::div3(10'(b0) + {1'b0, b1, 1'b0});
      end
      blk.sel = colour_word[63:32];
      ai      = '0;
      for (int j = 0; j < 16; j++) begin
         ai = alpha_word[16 + 3*j +: 3];
         if (punch) begin
            blk.alpha[j] = (three && blk.sel[j] == 2'd3) ? ctbd_pkg::ALPHA_CLEAR
                                                         : ctbd_pkg::ALPHA_OPAQUE;
         end else if (explicit_alpha) begin
            blk.alpha[j] = ctbd_pkg::widen4(alpha_word[4*j +: 4]);
         end else begin
            blk.alpha[j] = apal[ai];
         end
      end
   end

endmodule

// ===== src/ctbd_emit.sv =====
module ctbd_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                blk_valid,
   output logic                blk_ready,
   input  ctbd_pkg::block_type blk,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   output logic [7:0]          rsp_alpha,
   output logic [3:0]          rsp_texel_index,
   output logic                rsp_last_texel
);

   ctbd_pkg::block_type blk_ff;
   logic                blk_valid_ff;
   logic [3:0]          cnt_ff;
   logic                fire, last;
   logic [1:0]          s;
   logic                rsp_valid_ff, rsp_last_ff;
   logic [7:0]          red_ff, green_ff, blue_ff, alpha_ff;
   logic [3:0]          index_ff;

   assign fire      = blk_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign last      = (cnt_ff == 4'd15);
   assign blk_ready = !blk_valid_ff || (fire && last);
   assign s         = blk_ff.sel[cnt_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (blk_valid && blk_ready) begin
            blk_valid_ff <= 1'b1;
         end else if (fire && last) begin
            blk_valid_ff <= 1'b0;
         end
         if (fire) begin
            cnt_ff       <= cnt_ff + 4'd1;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (blk_valid && blk_ready) begin
         blk_ff <= blk;
      end
      if (fire) begin
         red_ff      <= blk_ff.red[s];
         green_ff    <= blk_ff.green[s];
         blue_ff     <= blk_ff.blue[s];
         alpha_ff    <= blk_ff.alpha[cnt_ff];
         index_ff    <= cnt_ff;
         rsp_last_ff <= last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = blue_ff;
   assign rsp_alpha       = alpha_ff;
   assign rsp_texel_index = index_ff;
   assign rsp_last_texel  = rsp_last_ff;

endmodule

// ===== src/compressed_texture_block_decoder_top.sv =====
// Channel    | Direction | Handshake          | Payload
// -----------+-----------+--------------------+-----------------------------------------
// req        | in        | req_valid/req_stall| req_block_word (64-bit block half)
// rsp        | out       | rsp_valid/rsp_stall| rsp_red/green/blue/alpha, texel_index, last
// csr (APB)  | in/out    | psel/penable/pready| paddr, pwdata, prdata (compression_mode)
//
// A colour word produces sixteen texels, one per cycle unless rsp stalls; the texel
// emitter over the block register sets that rate.
// Path: accept into the input register, then into the block register, then into the
// output register as the first texel. Alpha words are only held and yield nothing.
// The next word is taken while the current block is still being emitted.
// Synchronous active-high reset clears all valids, the mode and the pending flag.
// A stalled rsp holds every payload; req_stall rises only while the input
// register is full and the block register cannot take it.
module compressed_texture_block_decoder_top (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_word,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [3:0]  rsp_texel_index,
   output logic        rsp_last_texel,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [1:0]          mode_ff;
   logic [63:0]         held_alpha_ff;
   logic                pending_ff;
   logic                cfg_wr;
   logic                punch, accept, take_alpha, take_colour;

   // input register: colour word plus the alpha half it pairs with
   logic                a_valid_ff;
   logic [63:0]         a_word_ff;
   logic [63:0]         a_alpha_ff;
   logic                a_punch_ff;
   logic                a_dxt3_ff;

   logic                blk_ready;
   ctbd_pkg::block_type blk;

   // the spare mode code behaves as DXT1
   assign punch = (mode_ff != ctbd_pkg::MODE_DXT3) && (mode_ff != ctbd_pkg::MODE_DXT5);

   // APB: single register, zero-wait
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr[2] == ctbd_pkg::REG_MODE);
   assign prdata = (paddr[2] == ctbd_pkg::REG_MODE) ? {30'd0, mode_ff} : 32'd0;

   // hold the request while the input register cannot drain
   assign req_stall   = a_valid_ff && !blk_ready;
   assign accept      = req_valid && !req_stall;
   assign take_alpha  = accept && !punch && !pending_ff;
   assign take_colour = accept && !take_alpha;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= ctbd_pkg::MODE_DXT1;
         pending_ff <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         // a mode write restarts block pairing
         if (cfg_wr) begin
            mode_ff    <= pwdata[1:0];
            pending_ff <= 1'b0;
         end else if (take_alpha) begin
            pending_ff <= 1'b1;
         end else if (take_colour) begin
            pending_ff <= 1'b0;
         end
         if (take_colour) begin
            a_valid_ff <= 1'b1;
         end else if (blk_ready) begin
            a_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_alpha_ff <= '0;
      end else if (take_alpha) begin
         held_alpha_ff <= req_block_word;
      end
   end

   // capture the alpha half alongside the colour word so a following alpha
   // word cannot overwrite it before decode
   always_ff @(posedge clock) begin
      if (take_colour) begin
         a_word_ff  <= req_block_word;
         a_alpha_ff <= held_alpha_ff;
         a_punch_ff <= punch;
         a_dxt3_ff  <= (mode_ff == ctbd_pkg::MODE_DXT3);
      end
   end

   ctbd_palette u_palette (
      .colour_word    (a_word_ff),
      .alpha_word     (a_alpha_ff),
      .punch          (a_punch_ff),
      .explicit_alpha (a_dxt3_ff),
      .blk            (blk)
   );

   ctbd_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .blk_valid       (a_valid_ff),
      .blk_ready       (blk_ready),
      .blk             (blk),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_texel_index (rsp_texel_index),
      .rsp_last_texel  (rsp_last_texel)
   );

   // inside a block the texels arrive without gaps
   a_texel_burst : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_texel |=> rsp_valid)
      else $error("texel burst broken inside a block");

   // after the last texel the next result opens a new block
   a_block_restart : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_texel |=> !rsp_valid || rsp_texel_index == 4'd0)
      else $error("new block does not start at texel zero");

   // no alpha half can be outstanding in a single-word mode
   a_pending_mode : assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> !punch)
      else $error("alpha word pending in DXT1 mode");

   // texel index and last flag agree
   a_last_index : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_texel == (rsp_texel_index == 4'd15)))
      else $error("last flag out of step with texel index");

endmodule
